// File: rtl/mfs_pkg.sv
// Package for the matrix factorization SGD step engine.
// Holds command codes, register indexes, fixed-point widths and helper functions.
// Used by mfs_csr, the top level and the testbench; depends on nothing.
package mfs_pkg;

   localparam int ValueWidth = 32;
   localparam int TotalWidth = 48;
   localparam int RateWidth = 25;
   localparam int FracBits = 24;

   typedef enum logic [2:0] {
      CMD_WRITE_USER = 3'd0,
      CMD_WRITE_ITEM = 3'd1,
      CMD_READ_USER  = 3'd2,
      CMD_READ_ITEM  = 3'd3,
      CMD_NEIGHBOR   = 3'd4,
      CMD_TRAIN      = 3'd5,
      CMD_EVALUATE   = 3'd6,
      CMD_CLEAR      = 3'd7
   } command_type;

   localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
   localparam logic [1:0] REG_DECAY_WEIGHT  = 2'd1;
   localparam logic [1:0] REG_NEIGHBOR_GAIN = 2'd2;

   localparam logic [RateWidth-1:0] LEARNING_RATE_RESET = 25'd83886;
   localparam logic [RateWidth-1:0] DECAY_WEIGHT_RESET  = 25'd335544;
   localparam logic [RateWidth-1:0] NEIGHBOR_GAIN_RESET = 25'd1678;

   // Saturate a 40 bit signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = 40'sh007FFFFFFF;
      lo = -40'sh0080000000;
      if (v > hi) sat32 = 32'sh7FFFFFFF;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

   // Saturate a 48 bit signed dot product difference to 32 bits.
   function automatic logic signed [31:0] sat32_acc(input logic signed [47:0] v);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = 48'sh00007FFFFFFF;
      lo = -48'sh000080000000;
      if (v > hi) sat32_acc = 32'sh7FFFFFFF;
      else if (v < lo) sat32_acc = 32'sh80000000;
      else sat32_acc = v[31:0];
   endfunction

endpackage

// File: rtl/mfs_ram.sv
// Generic single-port synchronous RAM with a registered read.
// One access per cycle, a write also returning the old entry; no dependencies.
module mfs_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write or read the addressed entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/mfs_csr.sv
// Configuration registers of the SGD engine on an APB-style port.
// Depends on mfs_pkg for register indexes and reset values.
module mfs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [3:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output logic [mfs_pkg::RateWidth-1:0] learning_rate,
   output logic [mfs_pkg::RateWidth-1:0] decay_weight,
   output logic [mfs_pkg::RateWidth-1:0] neighbor_gain
);
   import mfs_pkg::*;

   logic [RateWidth-1:0] eta_ff, dw_ff, ng_ff;
   logic                 wr;
   logic [1:0]           idx;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[3:2];

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff <= LEARNING_RATE_RESET;
         dw_ff  <= DECAY_WEIGHT_RESET;
         ng_ff  <= NEIGHBOR_GAIN_RESET;
      end else if (wr && csr_paddr[1:0] == 2'd0) begin
         if (idx == REG_LEARNING_RATE) eta_ff <= csr_pwdata[RateWidth-1:0];
         if (idx == REG_DECAY_WEIGHT)  dw_ff  <= csr_pwdata[RateWidth-1:0];
         if (idx == REG_NEIGHBOR_GAIN) ng_ff  <= csr_pwdata[RateWidth-1:0];
      end
   end

   // Read back.
   always_comb begin
      csr_prdata = '0;
      if (idx == REG_LEARNING_RATE) csr_prdata = {7'd0, eta_ff};
      else if (idx == REG_DECAY_WEIGHT) csr_prdata = {7'd0, dw_ff};
      else if (idx == REG_NEIGHBOR_GAIN) csr_prdata = {7'd0, ng_ff};
   end

   assign learning_rate = eta_ff;
   assign decay_weight  = dw_ff;
   assign neighbor_gain = ng_ff;
endmodule

// File: rtl/matrix_factorization_sgd_step.sv
// Matrix factorization SGD step engine, top level; one transaction at a time.
// The pace of element reads and writes, neighbour items, train and evaluate is set by the
// single port of each factor RAM and the one shared multiplier.
// Synchronous reset clears control, neighbour sums (valid bits), error totals and CSR registers;
// factor RAMs are undefined until written and need no clearing.
module matrix_factorization_sgd_step #(
   parameter int LATENT_DIM = 16,
   parameter int USER_ROWS = 1024,
   parameter int ITEM_ROWS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: command[2:0], row_index[12:3], col_index[22:13], lane_index[26:23],
   // sample_value[58:27], neighbor_scale[90:59], zero fill to 96
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: result_value[31:0], error_sum[79:32]
   output logic [79:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mfs_pkg::*;

   localparam int LW = (LATENT_DIM > 1) ? $clog2(LATENT_DIM) : 1;
   localparam int UDEPTH = USER_ROWS * LATENT_DIM;
   localparam int IDEPTH = ITEM_ROWS * LATENT_DIM;
   localparam int UAW = $clog2(UDEPTH);
   localparam int IAW = $clog2(IDEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_ELEM, S_ELEM_W, S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_ERR, S_SQ,
      S_UPD_RD, S_UPD_M, S_UPD_W, S_NB_RD, S_NB_MUL, S_NB_ACC, S_OUT
   } state_type;

   logic [RateWidth-1:0] eta, dw, ng;
   mfs_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready,
      .learning_rate(eta), .decay_weight(dw), .neighbor_gain(ng)
   );

   state_type state_ff;
   logic [2:0]  cmd_ff;
   logic [9:0]  row_ff, col_ff;
   logic [3:0]  lane_ff;
   logic signed [31:0] x_ff, w_ff;
   logic [LW-1:0] l_ff;
   logic [2:0]  ph_ff;
   logic signed [47:0] acc_ff;
   logic signed [31:0] e_ff, u_ff, v_ff, gu_ff, gv_ff;
   logic signed [39:0] t_ff;
   logic signed [63:0] p_ff;
   logic [TotalWidth-1:0] train_ff, test_ff;
   logic signed [31:0] nb_ff [LATENT_DIM];
   logic [LATENT_DIM-1:0] nbv_ff;
   logic [31:0] res_ff;
   logic [TotalWidth-1:0] sum_ff;
   logic ok_ff;

   // Factor memories.
   logic u_we, i_we;
   logic [UAW-1:0] u_addr;
   logic [IAW-1:0] i_addr;
   logic [31:0] u_wd, i_wd, u_rd, i_rd;
   mfs_ram #(.Width(32), .Depth(UDEPTH)) u_user (
      .clock, .wr_en(u_we), .addr(u_addr), .wr_data(u_wd), .rd_data(u_rd));
   mfs_ram #(.Width(32), .Depth(IDEPTH)) u_item (
      .clock, .wr_en(i_we), .addr(i_addr), .wr_data(i_wd), .rd_data(i_rd));

   logic [LW-1:0] lane_sel;
   logic [31:0] l_ext;
   always_comb begin
      lane_sel = (state_ff == S_ELEM || state_ff == S_ELEM_W) ? lane_ff[LW-1:0] : l_ff;
      u_addr = UAW'(32'(row_ff) * 32'(LATENT_DIM) + 32'(lane_sel));
      i_addr = IAW'(32'(col_ff) * 32'(LATENT_DIM) + 32'(lane_sel));
      l_ext = 32'(l_ff);
   end

   // Shared multiplier operands, one product per cycle registered.
   logic signed [31:0] ma, mb;
   logic signed [63:0] prod;
   logic signed [39:0] pq;
   logic signed [31:0] nb_cur;
   assign nb_cur = nbv_ff[l_ff] ? nb_ff[l_ff] : 32'sd0;
   always_comb begin
      ma = u_ff; mb = v_ff;
      unique case (state_ff)
         S_DOT_MUL: begin ma = $signed(u_rd); mb = $signed(i_rd); end
         S_SQ:      begin ma = e_ff; mb = e_ff; end
         S_NB_MUL:  begin ma = $signed(i_rd); mb = w_ff; end
         S_UPD_M: begin
            unique case (ph_ff)
               3'd0: begin ma = e_ff; mb = v_ff; end
               3'd1: begin ma = $signed({7'd0, dw}); mb = u_ff; end
               3'd2: begin ma = e_ff; mb = u_ff; end
               3'd3: begin ma = $signed({7'd0, dw}); mb = v_ff; end
               3'd4: begin ma = $signed({7'd0, ng}); mb = nb_cur; end
               3'd5: begin ma = $signed({7'd0, eta}); mb = gu_ff; end
               3'd6: begin ma = $signed({7'd0, eta}); mb = gv_ff; end
               // Repeat eta*gv so that it is still present during the write-back.
               3'd7: begin ma = $signed({7'd0, eta}); mb = gv_ff; end
               default: begin ma = u_ff; mb = v_ff; end
            endcase
         end
         default: begin ma = u_ff; mb = v_ff; end
      endcase
      prod = ma * mb;
   end
   assign pq = 40'(p_ff >>> FracBits);

   logic [TotalWidth:0] tot_add;
   logic [TotalWidth-1:0] tot_src, sq;
   assign sq = TotalWidth'(p_ff >>> FracBits);
   assign tot_src = (cmd_ff == CMD_TRAIN) ? train_ff : test_ff;
   assign tot_add = {1'b0, tot_src} + {1'b0, sq};

   logic last_l;
   assign last_l = (l_ext == 32'(LATENT_DIM - 1));
   logic r_ok, c_ok, l_ok;
   assign r_ok = 32'(row_ff) < 32'(USER_ROWS);
   assign c_ok = 32'(col_ff) < 32'(ITEM_ROWS);
   assign l_ok = 32'(lane_ff) < 32'(LATENT_DIM);

   // Range check of a single-element access, valid while the command is decoded.
   logic elem_ok;
   assign elem_ok = ((cmd_ff == CMD_WRITE_USER || cmd_ff == CMD_READ_USER) ? r_ok : c_ok)
                    && l_ok;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {sum_ff, res_ff};

   always_comb begin
      u_we = 1'b0; i_we = 1'b0; u_wd = x_ff; i_wd = x_ff;
      if (state_ff == S_ELEM && elem_ok) begin
         u_we = (cmd_ff == CMD_WRITE_USER);
         i_we = (cmd_ff == CMD_WRITE_ITEM);
      end
      if (state_ff == S_UPD_W) begin
         u_we = 1'b1; i_we = 1'b1;
         u_wd = sat32(40'(u_ff) + t_ff);
         i_wd = sat32(40'(v_ff) + pq);
      end
   end

   // Sequencer: one transaction at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         train_ff <= '0;
         test_ff <= '0;
         nbv_ff <= '0;
      end else begin
         p_ff <= prod;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               cmd_ff <= req_tdata[2:0];
               row_ff <= req_tdata[12:3];
               col_ff <= req_tdata[22:13];
               lane_ff <= req_tdata[26:23];
               x_ff <= $signed(req_tdata[58:27]);
               w_ff <= $signed(req_tdata[90:59]);
               l_ff <= '0;
               ph_ff <= '0;
               acc_ff <= '0;
               res_ff <= '0;
               sum_ff <= '0;
               state_ff <= S_ELEM;
            end
            S_ELEM: begin
               ok_ff <= elem_ok;
               unique case (cmd_ff)
                  CMD_WRITE_USER, CMD_WRITE_ITEM, CMD_READ_USER, CMD_READ_ITEM:
                     state_ff <= S_ELEM_W;
                  CMD_NEIGHBOR: state_ff <= c_ok ? S_NB_RD : S_OUT;
                  CMD_TRAIN: begin
                     state_ff <= (r_ok && c_ok) ? S_DOT_RD : S_OUT;
                     sum_ff <= train_ff;
                  end
                  CMD_EVALUATE: begin
                     state_ff <= (r_ok && c_ok) ? S_DOT_RD : S_OUT;
                     sum_ff <= test_ff;
                  end
                  default: begin
                     nbv_ff <= '0; train_ff <= '0; test_ff <= '0;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_ELEM_W: begin
               // Write happened last cycle if enabled; now the read data for the lane.
               if (ok_ff && cmd_ff == CMD_READ_USER) res_ff <= u_rd;
               if (ok_ff && cmd_ff == CMD_READ_ITEM) res_ff <= i_rd;
               state_ff <= S_OUT;
            end
            S_DOT_RD: state_ff <= S_DOT_MUL;
            S_DOT_MUL: state_ff <= S_DOT_ACC;
            S_DOT_ACC: begin
               acc_ff <= acc_ff + 48'(pq);
               if (last_l) state_ff <= S_ERR;
               else begin l_ff <= l_ff + 1'b1; state_ff <= S_DOT_RD; end
            end
            S_ERR: begin
               e_ff <= sat32_acc(48'(x_ff) - acc_ff);
               state_ff <= S_SQ;
            end
            S_SQ: begin
               if (ph_ff == 3'd0) ph_ff <= 3'd1;
               else begin
                  ph_ff <= '0;
                  res_ff <= e_ff;
                  if (tot_add[TotalWidth]) sum_ff <= '1;
                  else sum_ff <= tot_add[TotalWidth-1:0];
                  if (cmd_ff == CMD_TRAIN) begin
                     train_ff <= tot_add[TotalWidth] ? '1 : tot_add[TotalWidth-1:0];
                     l_ff <= '0;
                     state_ff <= S_UPD_RD;
                  end else begin
                     test_ff <= tot_add[TotalWidth] ? '1 : tot_add[TotalWidth-1:0];
                     state_ff <= S_OUT;
                  end
               end
            end
            S_UPD_RD: begin
               // With ph_ff at 0 the read is issued; with ph_ff at 1 the old elements are taken.
               if (ph_ff == 3'd1) begin
                  u_ff <= $signed(u_rd); v_ff <= $signed(i_rd);
                  ph_ff <= '0;
                  state_ff <= S_UPD_M;
               end else begin
                  ph_ff <= 3'd1;
               end
            end
            S_UPD_M: begin
               // Product issued at ph; its truncation appears next cycle in pq.
               ph_ff <= ph_ff + 1'b1;
               unique case (ph_ff)
                  3'd1: t_ff <= pq;
                  3'd2: gu_ff <= sat32(t_ff - pq);
                  3'd3: t_ff <= pq;
                  3'd4: t_ff <= t_ff - pq;
                  3'd5: gv_ff <= sat32(t_ff + pq);
                  3'd6: t_ff <= pq;
                  3'd7: begin
                     t_ff <= t_ff;
                     state_ff <= S_UPD_W;
                  end
                  default: ;
               endcase
            end
            S_UPD_W: begin
               // Writes issue now; t_ff holds eta*gu and pq holds eta*gv.
               ph_ff <= '0;
               if (last_l) begin
                  nbv_ff <= '0;
                  state_ff <= S_OUT;
               end else begin
                  l_ff <= l_ff + 1'b1;
                  state_ff <= S_UPD_RD;
               end
            end
            S_NB_RD: state_ff <= S_NB_MUL;
            S_NB_MUL: state_ff <= S_NB_ACC;
            S_NB_ACC: begin
               nb_ff[l_ff] <= sat32(40'(nb_cur) + pq);
               nbv_ff[l_ff] <= 1'b1;
               if (last_l) state_ff <= S_OUT;
               else begin l_ff <= l_ff + 1'b1; state_ff <= S_NB_RD; end
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: bench/matrix_factorization_sgd_step_test.sv
// Testbench for the matrix factorization SGD step engine.
// A scoreboard class predicts every response from its own copy of the factor tables.
// Depends on mfs_pkg and matrix_factorization_sgd_step.
module matrix_factorization_sgd_step_test;
   import mfs_pkg::*;

   localparam int Lanes = 16;
   localparam int Rows = 1024;
   localparam longint TotalMax = 64'hFFFF_FFFF_FFFF;
   localparam longint CycleLimit = 4000000;

   typedef struct {
      int          result;
      logic [47:0] total;
   } sgd_result_t;

   // Fixed-point predictor of the engine with the queue of expected responses.
   class sgd_scoreboard;
      int user_tab[Rows*Lanes];
      int item_tab[Rows*Lanes];
      int nsum[Lanes];
      logic [47:0] train_tot;
      logic [47:0] test_tot;
      longint eta, dw, ng;
      sgd_result_t pending_results[$];
      int errors;
      int checked;

      function new();
         foreach (nsum[l]) nsum[l] = 0;
         train_tot = '0;
         test_tot = '0;
         eta = LEARNING_RATE_RESET;
         dw = DECAY_WEIGHT_RESET;
         ng = NEIGHBOR_GAIN_RESET;
         errors = 0;
         checked = 0;
      endfunction

      // Q8.24 product, truncated toward minus infinity.
      function longint qmul(longint a, longint b);
         return (a * b) >>> 24;
      endfunction

      function int clamp_q(longint v);
         if (v > 64'sd2147483647) return 32'h7FFFFFFF;
         if (v < -64'sd2147483648) return 32'h80000000;
         return int'(v);
      endfunction

      function logic [47:0] add_square(logic [47:0] tot, int e);
         longint sq;
         sq = qmul(e, e);
         if (sq > TotalMax - longint'({16'd0, tot})) return TotalMax[47:0];
         return tot + sq[47:0];
      endfunction

      function int dot_error(int r, int c, int x);
         longint acc;
         acc = 0;
         for (int l = 0; l < Lanes; l++)
            acc += qmul(user_tab[r*Lanes+l], item_tab[c*Lanes+l]);
         return clamp_q(longint'(x) - acc);
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] v);
         case (idx)
            REG_LEARNING_RATE: eta = v[24:0];
            REG_DECAY_WEIGHT:  dw = v[24:0];
            REG_NEIGHBOR_GAIN: ng = v[24:0];
            default: ;
         endcase
      endfunction

      // Apply one accepted request to the model and queue its response.
      function void note_request(logic [95:0] d);
         command_type op;
         int r, c, lane, x, w, e, gu, gv;
         longint u, v;
         sgd_result_t exp_rsp;
         op = command_type'(d[2:0]);
         r = d[12:3];
         c = d[22:13];
         lane = d[26:23];
         x = d[58:27];
         w = d[90:59];
         exp_rsp.result = 0;
         exp_rsp.total = '0;
         case (op)
            CMD_WRITE_USER: user_tab[r*Lanes+lane] = x;
            CMD_WRITE_ITEM: item_tab[c*Lanes+lane] = x;
            CMD_READ_USER:  exp_rsp.result = user_tab[r*Lanes+lane];
            CMD_READ_ITEM:  exp_rsp.result = item_tab[c*Lanes+lane];
            CMD_NEIGHBOR: begin
               for (int l = 0; l < Lanes; l++)
                  nsum[l] = clamp_q(longint'(nsum[l]) + qmul(item_tab[c*Lanes+l], w));
            end
            CMD_TRAIN: begin
               e = dot_error(r, c, x);
               train_tot = add_square(train_tot, e);
               for (int l = 0; l < Lanes; l++) begin
                  u = user_tab[r*Lanes+l];
                  v = item_tab[c*Lanes+l];
                  gu = clamp_q(qmul(e, v) - qmul(dw, u));
                  gv = clamp_q(qmul(e, u) - qmul(dw, v) + qmul(ng, nsum[l]));
                  user_tab[r*Lanes+l] = clamp_q(u + qmul(eta, gu));
                  item_tab[c*Lanes+l] = clamp_q(v + qmul(eta, gv));
               end
               foreach (nsum[l]) nsum[l] = 0;
               exp_rsp.result = e;
               exp_rsp.total = train_tot;
            end
            CMD_EVALUATE: begin
               e = dot_error(r, c, x);
               test_tot = add_square(test_tot, e);
               exp_rsp.result = e;
               exp_rsp.total = test_tot;
            end
            default: begin
               foreach (nsum[l]) nsum[l] = 0;
               train_tot = '0;
               test_tot = '0;
            end
         endcase
         pending_results.push_back(exp_rsp);
      endfunction

      // Compare one response with the oldest expectation.
      function void check_result(logic [79:0] d);
         sgd_result_t exp_rsp;
         if (pending_results.size() == 0) begin
            $error("Unexpected response: result_value %0d error_sum %0d",
                   $signed(d[31:0]), d[79:32]);
            errors++;
            return;
         end
         exp_rsp = pending_results.pop_front();
         checked++;
         if (d[31:0] !== exp_rsp.result) begin
            $error("result_value: expected %0d, actual %0d", exp_rsp.result, $signed(d[31:0]));
            errors++;
         end
         if (d[79:32] !== exp_rsp.total) begin
            $error("error_sum: expected %0d, actual %0d", exp_rsp.total, d[79:32]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sgd_scoreboard sb = new();
   longint cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int sent_count = 0;
   int random_count = 0;
   int random_base = 0;
   int user_full[$];
   int item_full[$];
   bit user_is_full[Rows];
   bit item_is_full[Rows];

   matrix_factorization_sgd_step i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // Response side: check accepted responses, throttle tready, watch the cycle limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request transaction and return once it has been accepted.
   task automatic send_item(command_type op, int r, int c, int lane, int x, int w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, w[31:0], x[31:0], lane[3:0], c[9:0], r[9:0], op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(req_tdata);
      sent_count++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_register(idx, v);
   endtask

   // Small Q8.24 values in small_pct percent of calls so training stays in range, else any bit pattern.
   function automatic int pick_value(int small_pct);
      if ($urandom_range(99) < small_pct) return int'($urandom_range(1 << 25)) - (1 << 24);
      return $urandom;
   endfunction

   // Write every lane of one factor row; a fixed value of zero means random content.
   task automatic fill_row(bit is_item, int row, int fixed_value);
      for (int l = 0; l < Lanes; l++)
         send_item(is_item ? CMD_WRITE_ITEM : CMD_WRITE_USER, row, row, l,
                   fixed_value != 0 ? fixed_value : pick_value(85), $urandom);
      if (is_item && !item_is_full[row]) begin
         item_is_full[row] = 1'b1;
         item_full.push_back(row);
      end else if (!is_item && !user_is_full[row]) begin
         user_is_full[row] = 1'b1;
         user_full.push_back(row);
      end
   endtask

   function automatic int any_user();
      return user_full[$urandom_range(user_full.size() - 1)];
   endfunction

   function automatic int any_item();
      return item_full[$urandom_range(item_full.size() - 1)];
   endfunction

   // Traffic pattern follows the number of random requests sent so far.
   function automatic void set_traffic();
      if (random_count < 450) begin
         send_idle_pct = 16;
         recv_idle_pct = 88;
      end else if (random_count < 900) begin
         send_idle_pct = 88;
         recv_idle_pct = 16;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endfunction

   // One random sequence: most often neighbour gathering followed by a training step.
   task automatic random_sequence();
      int kind;
      int pool_row;
      kind = $urandom_range(99);
      pool_row = ($urandom_range(3) == 0) ? $urandom_range(Rows - 1) : $urandom_range(7) * 73;
      if (kind < 8) begin
         fill_row($urandom_range(1), pool_row, 0);
      end else if (kind < 45) begin
         repeat ($urandom_range(3))
            send_item(CMD_NEIGHBOR, $urandom, any_item(), $urandom, $urandom, pick_value(70));
         send_item(CMD_TRAIN, any_user(), any_item(), $urandom, pick_value(80), $urandom);
      end else if (kind < 60) begin
         send_item(CMD_EVALUATE, any_user(), any_item(), $urandom, pick_value(60), $urandom);
      end else if (kind < 70) begin
         send_item(CMD_READ_USER, any_user(), $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 80) begin
         send_item(CMD_READ_ITEM, $urandom, any_item(), $urandom, $urandom, $urandom);
      end else if (kind < 88) begin
         send_item($urandom_range(1) ? CMD_WRITE_ITEM : CMD_WRITE_USER,
                   any_user(), any_item(), $urandom, pick_value(80), $urandom);
      end else if (kind < 92) begin
         send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         send_item(CMD_NEIGHBOR, $urandom, any_item(), $urandom, $urandom, pick_value(50));
      end
   endtask

   initial begin
      int start_count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset register values: extreme rows, saturation, neighbours.
      send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
      fill_row(1'b0, Rows - 1, 32'h7FFFFFFF);
      fill_row(1'b1, 0, 32'h80000000);
      send_item(CMD_READ_USER, Rows - 1, 0, Lanes - 1, 0, 0);
      send_item(CMD_READ_ITEM, 0, 0, 0, 0, 0);
      send_item(CMD_TRAIN, Rows - 1, 0, 0, 32'h7FFFFFFF, 0);
      send_item(CMD_EVALUATE, Rows - 1, 0, 0, 32'h80000000, 0);
      send_item(CMD_NEIGHBOR, 0, 0, 0, 0, 32'h7FFFFFFF);
      send_item(CMD_NEIGHBOR, 0, 0, 0, 0, 32'h80000000);
      send_item(CMD_TRAIN, Rows - 1, 0, 0, 0, 0);
      send_item(CMD_EVALUATE, Rows - 1, 0, 0, 0, 0);
      send_item(CMD_READ_ITEM, 0, 0, Lanes - 1, 0, 0);
      send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
      send_item(CMD_EVALUATE, Rows - 1, 0, 0, 32'h7FFFFFFF, 0);
      fill_row(1'b0, 0, 0);
      fill_row(1'b1, Rows - 1, 0);

      // Random part in four register settings, the extremes among them.
      random_base = sent_count;
      for (int b = 0; b < 4; b++) begin
         wait_idle();
         case (b)
            0: begin
               write_register(REG_LEARNING_RATE, LEARNING_RATE_RESET);
               write_register(REG_DECAY_WEIGHT, DECAY_WEIGHT_RESET);
               write_register(REG_NEIGHBOR_GAIN, NEIGHBOR_GAIN_RESET);
            end
            1: begin
               write_register(REG_LEARNING_RATE, 32'h01FF_FFFF);
               write_register(REG_DECAY_WEIGHT, 32'h0100_0000);
               write_register(REG_NEIGHBOR_GAIN, 32'h01FF_FFFF);
               hold_request = 3000;
            end
            2: begin
               write_register(REG_LEARNING_RATE, 32'd0);
               write_register(REG_DECAY_WEIGHT, 32'd0);
               write_register(REG_NEIGHBOR_GAIN, 32'd0);
            end
            default: begin
               write_register(REG_LEARNING_RATE, $urandom_range(32'h01FF_FFFF));
               write_register(REG_DECAY_WEIGHT, $urandom_range(32'h0080_0000));
               write_register(REG_NEIGHBOR_GAIN, $urandom_range(32'h01FF_FFFF));
            end
         endcase
         start_count = sent_count;
         while (sent_count - start_count < 338) begin
            set_traffic();
            random_sequence();
            random_count = sent_count - random_base;
         end
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         $error("Responses still missing: %0d", sb.pending_results.size());
         sb.errors++;
      end
      $display("Summary: %0d requests sent and %0d responses checked over four register",
               sent_count, sb.checked);
      $display("settings, three traffic patterns, a long response stall and extreme rows.");
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
